>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define PSRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("psrs assertion failed");

// consequent checked at the next edge after the antecedent
`define PSRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   `PSRS_ASSERT(lbl, clk, rst, ante |=> cons)

`endif

>>> src/psrs_pkg.sv
package psrs_pkg;

   localparam int PROGRAM_DEPTH = 256;
   localparam int RETURN_DEPTH  = 16;
   localparam int LABEL_SLOTS   = 64;

   localparam int OP_W     = 4;
   localparam int ID_W     = 6;
   localparam int LADDR_W  = 8;
   localparam int LEN_W    = 9;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 5;

   localparam int RS_IDX_W  = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
   localparam int RP_W      = $clog2(RETURN_DEPTH + 1);
   localparam int LBL_IDX_W = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_START  = 4'd0,
      OP_DEFINE = 4'd1,
      OP_WORD   = 4'd2,
      OP_LABEL  = 4'd3,
      OP_GOTO   = 4'd4,
      OP_GOSUB  = 4'd5,
      OP_RETURN = 4'd6,
      OP_END    = 4'd7,
      OP_TEST   = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUNNING   = 3'd0,
      ST_END       = 3'd1,
      ST_PAST      = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

endpackage

>>> src/psrs_ram.sv
module psrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/program_sequencer_return_stack.sv
// channel   | dir | handshake             | payload
// req       | in  | req_valid / req_ready | operation, label_id, label_address, test_true
// rsp       | out | rsp_valid / rsp_ready | next_address, status, return_depth
// csr       | in  | csr_valid / csr_ready | program_length
//
// one transaction per cycle sustained while rsp is not stalled; each accepted one passes
// through the input register (label table read alongside), then the result register
// define writes an undefined label at acceptance, so the next transaction sees it
// synchronous reset clears counter, status, stack depth, label valid bits, length
// a stalled rsp holds the execute stage; req_ready drops only when both are full
module program_sequencer_return_stack (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [psrs_pkg::OP_W-1:0]      req_operation,
   input  logic [psrs_pkg::ID_W-1:0]      req_label_id,
   input  logic [psrs_pkg::LADDR_W-1:0]   req_label_address,
   input  logic                           req_test_true,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [psrs_pkg::CNT_W-1:0]     rsp_next_address,
   output logic [psrs_pkg::STATUS_W-1:0]  rsp_status,
   output logic [psrs_pkg::DEPTH_W-1:0]   rsp_return_depth,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [psrs_pkg::LEN_W-1:0]     csr_program_length
);

   import psrs_pkg::*;

   logic                   req_accept;
   op_type                 req_op;
   logic                   id_in_range;
   logic [LBL_IDX_W-1:0]   lbl_idx;
   logic                   lbl_wr_en;
   logic [LADDR_W-1:0]     lbl_rd_data;
   logic [LABEL_SLOTS-1:0] label_valid_ff;

   logic [LEN_W-1:0]       program_length_ff;
   logic [LEN_W-1:0]       eff_len;

   logic                   ex_valid_ff;
   op_type                 ex_op_ff;
   logic                   ex_known_ff;
   logic                   ex_cond_ff;
   logic                   ex_advance;

   logic [CNT_W-1:0]       ctr_ff;
   logic [CNT_W-1:0]       ctr_in;
   status_type             halt_ff;
   status_type             halt_in;
   logic [RP_W-1:0]        rp_ff;
   logic [RP_W-1:0]        rp_in;
   logic                   push;
   logic [CNT_W-1:0]       store_ff [RETURN_DEPTH];
   logic [CNT_W-1:0]       stack_top;

   logic                   rsp_valid_ff;
   logic [CNT_W-1:0]       rsp_next_address_ff;
   status_type             rsp_status_ff;
   logic [RP_W-1:0]        rsp_depth_ff;

   // input side and label table
   assign req_op      = op_type'(req_operation);
   assign req_ready   = !ex_valid_ff || ex_advance;
   assign req_accept  = req_valid && req_ready;
   assign id_in_range = int'(req_label_id) < LABEL_SLOTS;
   assign lbl_idx     = LBL_IDX_W'(req_label_id);
   assign lbl_wr_en   = req_accept && (req_op == OP_DEFINE) && id_in_range &&
                        !label_valid_ff[lbl_idx];

   psrs_ram #(
      .WIDTH (LADDR_W),
      .DEPTH (LABEL_SLOTS)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lbl_wr_en),
      .wr_addr (lbl_idx),
      .wr_data (req_label_address),
      .rd_en   (req_accept),
      .rd_addr (lbl_idx),
      .rd_data (lbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         label_valid_ff <= '0;
      end else if (lbl_wr_en) begin
         label_valid_ff[lbl_idx] <= 1'b1;
      end
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else if (csr_valid) begin
         program_length_ff <= csr_program_length;
      end
   end

   assign eff_len = (int'(program_length_ff) > PROGRAM_DEPTH) ?
                    LEN_W'(PROGRAM_DEPTH) : program_length_ff;

   // execute stage register
   assign ex_advance = ex_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (req_ready) begin
         ex_valid_ff <= req_valid;
      end
      if (req_accept) begin
         ex_op_ff    <= req_op;
         ex_known_ff <= id_in_range && label_valid_ff[lbl_idx];
         ex_cond_ff  <= req_test_true;
      end
   end

   // next counter, status and stack depth
   assign stack_top = store_ff[RS_IDX_W'(rp_ff - 1'b1)];

   always_comb begin
      ctr_in  = ctr_ff;
      halt_in = halt_ff;
      rp_in   = rp_ff;
      push    = 1'b0;
      case (ex_op_ff)
         OP_START: begin
            ctr_in  = '0;
            rp_in   = '0;
            halt_in = (eff_len == '0) ? ST_PAST : ST_RUNNING;
         end
         OP_WORD, OP_LABEL, OP_GOTO, OP_GOSUB, OP_RETURN, OP_END, OP_TEST: begin
            if (halt_ff == ST_RUNNING) begin
               if (ctr_ff >= eff_len) begin
                  halt_in = ST_PAST;
               end else begin
                  case (ex_op_ff)
                     OP_WORD, OP_LABEL: begin
                        ctr_in = CNT_W'(ctr_ff + 1'b1);
                     end
                     OP_GOTO: begin
                        if (ex_known_ff) begin
                           ctr_in = CNT_W'(lbl_rd_data);
                        end else begin
                           halt_in = ST_UNKNOWN;
                        end
                     end
                     OP_GOSUB: begin
                        if (!ex_known_ff) begin
                           halt_in = ST_UNKNOWN;
                        end else if (int'(rp_ff) >= RETURN_DEPTH) begin
                           halt_in = ST_OVERFLOW;
                        end else begin
                           push   = 1'b1;
                           rp_in  = RP_W'(rp_ff + 1'b1);
                           ctr_in = CNT_W'(lbl_rd_data);
                        end
                     end
                     OP_RETURN: begin
                        if (rp_ff == '0) begin
                           halt_in = ST_UNDERFLOW;
                        end else begin
                           rp_in  = RP_W'(rp_ff - 1'b1);
                           ctr_in = stack_top;
                        end
                     end
                     OP_END: begin
                        halt_in = ST_END;
                     end
                     default: begin
                        ctr_in = ex_cond_ff ? CNT_W'(ctr_ff + 2'd1) : CNT_W'(ctr_ff + 2'd2);
                     end
                  endcase
                  if (halt_in == ST_RUNNING && ctr_in >= eff_len) begin
                     halt_in = ST_PAST;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff  <= '0;
         halt_ff <= ST_RUNNING;
         rp_ff   <= '0;
      end else if (ex_advance) begin
         ctr_ff  <= ctr_in;
         halt_ff <= halt_in;
         rp_ff   <= rp_in;
      end
   end

   // return address store
   always_ff @(posedge clock) begin
      if (ex_advance && push) begin
         store_ff[RS_IDX_W'(rp_ff)] <= CNT_W'(ctr_ff + 1'b1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ex_advance) begin
         rsp_next_address_ff <= ctr_in;
         rsp_status_ff       <= halt_in;
         rsp_depth_ff        <= rp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_next_address_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_return_depth = DEPTH_W'(rsp_depth_ff);

endmodule

>>> src/psrs_checker.sv
`include "assert_macros.svh"

module psrs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [psrs_pkg::CNT_W-1:0]     rsp_next_address,
   input logic [psrs_pkg::STATUS_W-1:0]  rsp_status,
   input logic [psrs_pkg::DEPTH_W-1:0]   rsp_return_depth
);

   import psrs_pkg::*;

   // no result straight after reset
   `PSRS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled transaction keeps its payload
   `PSRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_address) && $stable(rsp_status) && $stable(rsp_return_depth))

   // while running the counter stays inside the program store
   `PSRS_ASSERT(a_running_in_range, clock, reset, rsp_valid && rsp_status == ST_RUNNING |-> int'(rsp_next_address) < PROGRAM_DEPTH)

   // stack depth never beyond its capacity
   `PSRS_ASSERT(a_depth_bound, clock, reset, rsp_valid |-> int'(rsp_return_depth) <= RETURN_DEPTH)

endmodule

bind program_sequencer_return_stack psrs_checker u_psrs_checker (.*);

>>> tb/tb.sv
module tb;
   import psrs_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int PHASE_ITEMS = 120;
   localparam int FREE_IDS    = 48;

   typedef struct {
      logic [CNT_W-1:0]   next_address;
      status_type         status;
      logic [DEPTH_W-1:0] return_depth;
   } seq_result_type;

   class sequencer_scoreboard;
      logic [LEN_W-1:0]   length;
      logic [CNT_W-1:0]   pc;
      status_type         halt;
      logic [CNT_W-1:0]   ret_stack [RETURN_DEPTH];
      logic [DEPTH_W-1:0] ret_ptr;
      logic [LADDR_W-1:0] label_addr [LABEL_SLOTS];
      bit                 label_def [LABEL_SLOTS];
      seq_result_type     pending_q [$];
      int                 mismatches;
      int                 checked;
      int                 status_seen [8];

      function new();
         length = '0;
         pc = '0;
         halt = ST_RUNNING;
         ret_ptr = '0;
         foreach (label_def[i]) label_def[i] = 1'b0;
         foreach (status_seen[i]) status_seen[i] = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function int span();
         return (int'(length) > PROGRAM_DEPTH) ? PROGRAM_DEPTH : int'(length);
      endfunction

      function void check_past();
         if (halt == ST_RUNNING && int'(pc) >= span()) halt = ST_PAST;
      endfunction

      function void execute(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic cond);
         bit known;
         known = (int'(id) < LABEL_SLOTS) && label_def[id];
         case (op)
            OP_WORD, OP_LABEL: begin
               pc = pc + 1'b1;
            end
            OP_GOTO: begin
               if (known) pc = CNT_W'(label_addr[id]);
               else halt = ST_UNKNOWN;
            end
            OP_GOSUB: begin
               if (!known) halt = ST_UNKNOWN;
               else if (int'(ret_ptr) >= RETURN_DEPTH) halt = ST_OVERFLOW;
               else begin
                  ret_stack[ret_ptr] = pc + 1'b1;
                  ret_ptr = ret_ptr + 1'b1;
                  pc = CNT_W'(label_addr[id]);
               end
            end
            OP_RETURN: begin
               if (ret_ptr == 0) halt = ST_UNDERFLOW;
               else begin
                  ret_ptr = ret_ptr - 1'b1;
                  pc = ret_stack[ret_ptr];
               end
            end
            OP_END: begin
               halt = ST_END;
            end
            default: begin
               pc = pc + CNT_W'(cond ? 1 : 2);
            end
         endcase
         check_past();
      endfunction

      function void note(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                         logic [LADDR_W-1:0] addr, logic cond);
         if (op == OP_START) begin
            pc = '0;
            halt = ST_RUNNING;
            ret_ptr = '0;
            check_past();
         end else if (op == OP_DEFINE) begin
            if (int'(id) < LABEL_SLOTS && !label_def[id]) begin
               label_addr[id] = addr;
               label_def[id] = 1'b1;
            end
         end else if (op <= OP_TEST && halt == ST_RUNNING) begin
            check_past();
            if (halt == ST_RUNNING) execute(op, id, cond);
         end
         pending_q.push_back('{next_address: pc, status: halt, return_depth: ret_ptr});
      endfunction

      function void check(logic [CNT_W-1:0] addr, logic [STATUS_W-1:0] st,
                          logic [DEPTH_W-1:0] depth);
         seq_result_type exp;
         if (pending_q.size() == 0) begin
            $error("result transaction with none outstanding: %0d %0d %0d",
                   addr, st, depth);
            mismatches++;
            return;
         end
         exp = pending_q.pop_front();
         checked++;
         status_seen[int'(exp.status)]++;
         if (addr !== exp.next_address) begin
            $error("next_address: expected %0d, actual %0d", exp.next_address, addr);
            mismatches++;
         end
         if (st !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, st);
            mismatches++;
         end
         if (depth !== exp.return_depth) begin
            $error("return_depth: expected %0d, actual %0d", exp.return_depth, depth);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [ID_W-1:0]     req_label_id = '0;
   logic [LADDR_W-1:0]  req_label_address = '0;
   logic                req_test_true = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CNT_W-1:0]    rsp_next_address;
   logic [STATUS_W-1:0] rsp_status;
   logic [DEPTH_W-1:0]  rsp_return_depth;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_program_length = '0;

   sequencer_scoreboard sb;
   int req_gap_pct = 30;
   int rsp_stall_pct = 30;
   int rsp_hold = 0;
   int sent = 0;
   int writes = 0;
   logic [OP_W-1:0] prog_op [PROGRAM_DEPTH];
   logic [ID_W-1:0] prog_id [PROGRAM_DEPTH];

   program_sequencer_return_stack dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_label_id       (req_label_id),
      .req_label_address  (req_label_address),
      .req_test_true      (req_test_true),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_next_address   (rsp_next_address),
      .rsp_status         (rsp_status),
      .rsp_return_depth   (rsp_return_depth),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_program_length (csr_program_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side: check every accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_next_address, rsp_status, rsp_return_depth);
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
         rsp_hold = idle_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [LADDR_W-1:0] addr, input logic cond);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_label_id <= id;
      req_label_address <= addr;
      req_test_true <= cond;
      do @(posedge clock); while (!req_ready);
      sb.note(op, id, addr, cond);
      sent++;
   endtask

   task automatic drain_rsp(input int extra);
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      drain_rsp(4);
      csr_valid <= 1'b1;
      csr_program_length <= value;
      do @(posedge clock); while (!csr_ready);
      sb.length = value;
      csr_valid <= 1'b0;
      writes++;
   endtask

   function automatic logic [ID_W-1:0] pick_label(int plen);
      logic [ID_W-1:0] id;
      for (int t = 0; t < 12; t++) begin
         id = ID_W'($urandom_range(0, FREE_IDS - 1));
         if (sb.label_def[id] && int'(sb.label_addr[id]) < plen) return id;
      end
      return ID_W'($urandom_range(0, FREE_IDS - 1));
   endfunction

   function automatic logic [LADDR_W-1:0] label_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return LADDR_W'($urandom_range(0, 15));
      if (r < 90) return LADDR_W'($urandom_range(0, 255));
      return (r < 95) ? 8'd0 : 8'd255;
   endfunction

   task automatic send_noise(input bit any_id);
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      op = OP_W'($urandom_range(0, 15));
      id = ID_W'($urandom_range(0, 63));
      if (op == OP_DEFINE && !any_id) id = ID_W'($urandom_range(0, FREE_IDS - 1));
      send_req(op, id, LADDR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // defines, a start, then instructions at predicted counters and noise
   task automatic run_program(input bit any_id);
      int plen, steps, r;
      logic [ID_W-1:0] id;
      repeat ($urandom_range(0, 3))
         send_req(OP_DEFINE,
                  ID_W'(any_id ? $urandom_range(0, 63) : $urandom_range(0, FREE_IDS - 1)),
                  label_target(), 1'($urandom_range(0, 1)));
      plen = sb.span();
      for (int i = 0; i < plen; i++) begin
         r = $urandom_range(0, 99);
         prog_id[i] = pick_label(plen);
         if (r < 28) prog_op[i] = OP_WORD;
         else if (r < 42) prog_op[i] = OP_LABEL;
         else if (r < 56) prog_op[i] = OP_TEST;
         else if (r < 68) prog_op[i] = OP_GOTO;
         else if (r < 80) prog_op[i] = OP_GOSUB;
         else if (r < 90) prog_op[i] = OP_RETURN;
         else if (r < 95) prog_op[i] = OP_END;
         else begin
            prog_op[i] = r[0] ? OP_GOTO : OP_GOSUB;
            prog_id[i] = ID_W'($urandom_range(FREE_IDS, 63));
         end
      end
      // self-calling subroutine drives the stack to overflow
      if (plen > 0 && $urandom_range(0, 5) == 0) begin
         id = pick_label(plen);
         if (sb.label_def[id] && int'(sb.label_addr[id]) < plen) begin
            prog_op[sb.label_addr[id]] = OP_GOSUB;
            prog_id[sb.label_addr[id]] = id;
         end
      end
      send_req(OP_START, ID_W'($urandom_range(0, 63)), LADDR_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
      steps = $urandom_range(4, 80);
      while (steps > 0 && sb.halt == ST_RUNNING) begin
         if ($urandom_range(0, 99) < 7) send_noise(any_id);
         else send_req(prog_op[sb.pc], prog_id[sb.pc], LADDR_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
         steps--;
      end
      repeat ($urandom_range(0, 2))
         send_req(OP_W'($urandom_range(OP_WORD, OP_TEST)), ID_W'($urandom_range(0, 63)),
                  LADDR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [LEN_W-1:0] phase_length(int p);
      case (p)
         0: return 9'd16;
         1: return 9'd256;
         2: return 9'd1;
         3: return 9'd0;
         4: return 9'd511;
         5: return 9'd24;
         6: return 9'd2;
         7: return 9'd256;
         8: return 9'd8;
         9: return 9'd255;
         default: return LEN_W'($urandom_range(2, 64));
      endcase
   endfunction

   initial begin
      int phase_end;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_length(9'd8);
      send_req(OP_WORD, 6'd0, 8'd0, 1'b0);
      send_req(OP_DEFINE, 6'd0, 8'd5, 1'b0);
      send_req(OP_DEFINE, 6'd0, 8'd2, 1'b1);
      send_req(OP_DEFINE, 6'd63, 8'd255, 1'b0);
      send_req(OP_DEFINE, 6'd1, 8'd3, 1'b0);
      send_req(OP_DEFINE, 6'd2, 8'd7, 1'b0);
      send_req(OP_START, 6'd0, 8'd0, 1'b0);
      send_req(OP_LABEL, 6'd0, 8'd0, 1'b0);
      send_req(OP_TEST, 6'd0, 8'd0, 1'b1);
      send_req(OP_TEST, 6'd0, 8'd0, 1'b0);
      send_req(OP_GOTO, 6'd1, 8'd0, 1'b0);
      send_req(OP_GOSUB, 6'd0, 8'd0, 1'b0);
      send_req(OP_RETURN, 6'd0, 8'd0, 1'b0);
      send_req(OP_RETURN, 6'd0, 8'd0, 1'b0);
      send_req(OP_WORD, 6'd0, 8'd0, 1'b0);
      send_req(OP_START, 6'd0, 8'd0, 1'b0);
      send_req(OP_GOTO, 6'd5, 8'd0, 1'b0);
      send_req(OP_START, 6'd0, 8'd0, 1'b0);
      send_req(OP_GOTO, 6'd63, 8'd0, 1'b0);
      send_req(OP_START, 6'd0, 8'd0, 1'b0);
      send_req(OP_GOSUB, 6'd2, 8'd0, 1'b0);
      send_req(OP_TEST, 6'd0, 8'd0, 1'b0);
      send_req(OP_START, 6'd0, 8'd0, 1'b0);
      send_req(4'd9, 6'd0, 8'd0, 1'b1);
      send_req(4'd15, 6'd63, 8'd255, 1'b1);
      send_req(OP_END, 6'd0, 8'd0, 1'b0);

      for (int p = 0; sent < ITEM_TARGET; p++) begin
         write_length(phase_length(p));
         if (p % 4 == 2) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = $urandom_range(10, 60);
            rsp_stall_pct = $urandom_range(10, 60);
         end
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            run_program(sent > ITEM_TARGET - PHASE_ITEMS);
            if ($urandom_range(0, 15) == 0) drain_rsp(1);
         end
      end

      drain_rsp(10);
      $display("%0d request transactions, %0d results checked over %0d length settings",
               sent, sb.checked, writes);
      $display("by status: running %0d, end %0d, past length %0d, unknown label %0d,",
               sb.status_seen[ST_RUNNING], sb.status_seen[ST_END], sb.status_seen[ST_PAST],
               sb.status_seen[ST_UNKNOWN]);
      $display("   underflow %0d, overflow %0d",
               sb.status_seen[ST_UNDERFLOW], sb.status_seen[ST_OVERFLOW]);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("** program_sequencer_return_stack: PASSED **");
      end else begin
         $display("** program_sequencer_return_stack: FAILED **");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("** program_sequencer_return_stack: FAILED **");
      $finish;
   end

endmodule

>>> program_sequencer_return_stack.f
+incdir+src
src/psrs_pkg.sv
src/psrs_ram.sv
src/program_sequencer_return_stack.sv
src/psrs_checker.sv
tb/tb.sv
